// ===== rtl/md5_pkg.sv =====
// Shared types, constants and step tables for the MD5 digest engine.
`timescale 1ns / 1ps

package md5_pkg;

    typedef logic [31:0] word_t;

    // Chaining value after reset and after each finished digest
    localparam word_t INIT_A = 32'h67452301;
    localparam word_t INIT_B = 32'hEFCDAB89;
    localparam word_t INIT_C = 32'h98BADCFE;
    localparam word_t INIT_D = 32'h10325476;

    // Marker byte that opens the padding
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Per-step additive constants
    localparam word_t SINE_ROM [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Source of the word written into the block buffer
    typedef enum logic [2:0] {
        SRC_INPUT  = 3'd0,
        SRC_MARK   = 3'd1,
        SRC_ZERO   = 3'd2,
        SRC_LEN_LO = 3'd3,
        SRC_LEN_HI = 3'd4
    } push_src_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      push;       // write one word into the block buffer
        push_src_t push_src;
        logic      load_work;  // copy chain into a..d, prefetch first word
        logic      step_en;    // run one compression step
        logic      fold;       // add a..d into the chain
        logic      finish;     // move chain to output, restart message
    } md5_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic fill_last;   // buffer holds 15 words
        logic fill_len;    // buffer holds 14 words
        logic step_last;   // step 63 under way
        logic out_busy;    // digest still draining
        logic in_final;    // request ends the message
        logic in_full;     // request carries four bytes
    } md5_status_t;

    // Message word index used by a step
    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [5:0] q;
        logic [5:0] g;
        q = {2'b00, step[3:0]};
        unique case (step[5:4])
            2'd0:    g = q;
            2'd1:    g = q * 6'd5 + 6'd1;
            2'd2:    g = q * 6'd3 + 6'd5;
            default: g = q * 6'd7;
        endcase
        return g[3:0];
    endfunction

    // Left rotate amount of a step
    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        logic [4:0] s;
        unique case ({step[5:4], step[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Nonlinear mix of the round
    function automatic word_t round_mix(input logic [1:0] rnd, input word_t b,
                                        input word_t c, input word_t d);
        word_t f;
        unique case (rnd)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/md5_datapath.sv =====
// Datapath: block buffer, byte counter, compression step unit, chain and output registers.
`timescale 1ns / 1ps

module md5_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  md5_pkg::md5_cmd_t  cmd,
    output md5_pkg::md5_status_t status,
    input  logic [31:0]        s_tdata,   // [31:0] message_word
    input  logic [2:0]         s_tuser,   // [2:0] valid_bytes
    input  logic               s_tlast,   // end_of_message
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // [31:0] digest_word
    output logic [1:0]         m_tuser,   // [1:0] word_index
    output logic               m_tlast    // last_word
);
    import md5_pkg::*;

    word_t       blk_mem [16];
    word_t       rd_data_reg;
    logic [3:0]  rd_addr;
    logic [3:0]  fill_reg;
    logic [63:0] count_reg;
    logic [5:0]  step_reg;
    word_t       a_reg, b_reg, c_reg, d_reg;
    word_t       chain_reg [4];
    word_t       out_word_reg [4];
    logic        out_valid_reg;
    logic [1:0]  out_idx_reg;

    logic [2:0]  nb_eff;
    word_t       in_word;
    word_t       push_word;
    logic [63:0] len_bits;
    word_t       mix, sum;
    logic [63:0] rot64;
    word_t       nb;

    // Input word with the marker byte merged in on a short final request
    always_comb begin
        nb_eff = (s_tuser > 3'd4) ? 3'd4 : s_tuser;
        in_word = s_tdata;
        if (s_tlast) begin
            unique case (nb_eff)
                3'd0:    in_word = {24'h0, PAD_MARK};
                3'd1:    in_word = {16'h0, PAD_MARK, s_tdata[7:0]};
                3'd2:    in_word = {8'h0, PAD_MARK, s_tdata[15:0]};
                3'd3:    in_word = {PAD_MARK, s_tdata[23:0]};
                default: in_word = s_tdata;
            endcase
        end
    end

    assign len_bits = {count_reg[60:0], 3'b000};

    always_comb begin
        unique case (cmd.push_src)
            SRC_INPUT:  push_word = in_word;
            SRC_MARK:   push_word = {24'h0, PAD_MARK};
            SRC_LEN_LO: push_word = len_bits[31:0];
            SRC_LEN_HI: push_word = len_bits[63:32];
            default:    push_word = '0;
        endcase
    end

    // Block buffer: one write port, one registered read port
    assign rd_addr = cmd.load_work ? msg_index(6'd0) : msg_index(step_reg + 6'd1);

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            blk_mem[fill_reg] <= push_word;
        end
        rd_data_reg <= blk_mem[rd_addr];
    end

    // One compression step
    always_comb begin
        mix   = round_mix(step_reg[5:4], b_reg, c_reg, d_reg);
        sum   = a_reg + mix + SINE_ROM[step_reg] + rd_data_reg;
        rot64 = {sum, sum} << rot_amount(step_reg);
        nb    = b_reg + rot64[63:32];
    end

    // Fill position, byte count, step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            count_reg <= '0;
            step_reg  <= '0;
        end else begin
            if (cmd.push) begin
                fill_reg <= fill_reg + 4'd1;
            end
            if (cmd.push && cmd.push_src == SRC_INPUT) begin
                count_reg <= count_reg + (s_tlast ? 64'(nb_eff) : 64'd4);
            end else if (cmd.finish) begin
                count_reg <= '0;
            end
            if (cmd.load_work) begin
                step_reg <= '0;
            end else if (cmd.step_en) begin
                step_reg <= step_reg + 6'd1;
            end
        end
    end

    // Working registers and chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end else begin
            if (cmd.load_work) begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
            end else if (cmd.step_en) begin
                a_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= b_reg;
                b_reg <= nb;
            end
            if (cmd.fold) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end else if (cmd.finish) begin
                chain_reg[0] <= INIT_A;
                chain_reg[1] <= INIT_B;
                chain_reg[2] <= INIT_C;
                chain_reg[3] <= INIT_D;
            end
        end
    end

    // Output holding registers, drained one word per request
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_word_reg <= chain_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
            out_idx_reg   <= '0;
        end else if (out_valid_reg && m_tready) begin
            if (out_idx_reg == 2'd3) begin
                out_valid_reg <= 1'b0;
            end
            out_idx_reg <= out_idx_reg + 2'd1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg[out_idx_reg];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == 2'd3);

    assign status.fill_last = (fill_reg == 4'd15);
    assign status.fill_len  = (fill_reg == 4'd14);
    assign status.step_last = (step_reg == 6'd63);
    assign status.out_busy  = out_valid_reg;
    assign status.in_final  = s_tlast;
    assign status.in_full   = (nb_eff == 3'd4);

    // Fold comes right after the step counter wraps
    a_fold_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fold |-> step_reg == 6'd0)
        else $error("fold with step counter not wrapped");

    // A new digest never overwrites one still draining
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !out_valid_reg)
        else $error("digest loaded while output busy");

    // The fourth word taken empties the output
    a_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && m_tready && out_idx_reg == 2'd3) |=> !out_valid_reg)
        else $error("output still valid after last word");

endmodule

// ===== rtl/md5_ctrl.sv =====
// Controller: sequences word intake, padding, compression and digest handoff.
`timescale 1ns / 1ps

module md5_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  md5_pkg::md5_status_t status,
    output md5_pkg::md5_cmd_t    cmd
);
    import md5_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PAD    = 6'b000010,
        ST_PREP   = 6'b000100,
        ST_ROUND  = 6'b001000,
        ST_FOLD   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   final_reg, final_next;    // message end seen, padding under way
    logic   mark_reg, mark_next;      // marker word still owed
    logic   len_hi_reg, len_hi_next;  // low length word written

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        final_next  = final_reg;
        mark_next   = mark_reg;
        len_hi_next = len_hi_reg;
        cmd         = '0;
        cmd.push_src = SRC_INPUT;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.push   = 1'b1;
                    final_next = status.in_final;
                    mark_next  = status.in_final && status.in_full;
                    if (status.fill_last) begin
                        state_next = ST_PREP;
                    end else if (status.in_final) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.push = 1'b1;
                priority if (mark_reg) begin
                    cmd.push_src = SRC_MARK;
                    mark_next    = 1'b0;
                end else if (len_hi_reg) begin
                    cmd.push_src = SRC_LEN_HI;
                end else if (status.fill_len) begin
                    cmd.push_src = SRC_LEN_LO;
                    len_hi_next  = 1'b1;
                end else begin
                    cmd.push_src = SRC_ZERO;
                end
                if (status.fill_last) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.load_work = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.step_en = 1'b1;
                if (status.step_last) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                priority if (len_hi_reg) begin
                    state_next = ST_FINISH;
                end else if (final_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.finish  = 1'b1;
                    final_next  = 1'b0;
                    mark_next   = 1'b0;
                    len_hi_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            final_reg  <= 1'b0;
            mark_reg   <= 1'b0;
            len_hi_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            final_reg  <= final_next;
            mark_reg   <= mark_next;
            len_hi_reg <= len_hi_next;
        end
    end

    // Buffer is never written while rounds read it
    a_no_push_in_round: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_en |-> !cmd.push)
        else $error("buffer write during compression");

    // Step 63 hands over to the fold
    a_round_to_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && status.step_last) |=> state_reg == ST_FOLD)
        else $error("compression did not end in fold");

    // Length words only go out during padding of an ended message
    a_len_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && (cmd.push_src == SRC_LEN_LO || cmd.push_src == SRC_LEN_HI))
        |-> final_reg)
        else $error("length written outside padding");

endmodule

// ===== rtl/md5_digest_engine_core.sv =====
// Message words are accepted only while the controller is idle. A 16th buffered
// word starts a compression (a prefetch, 64 steps at one step per cycle in the
// round unit, and a fold); no words are accepted until it ends.
// The final request adds padding writes (one per cycle) and one or two
// compressions, then four digest words; intake resumes once they are queued.
// aresetn (synchronous) restores the initial chaining value and empties the output.
`timescale 1ns / 1ps

module md5_digest_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] message_word
    input  logic [2:0]  s_tuser,   // [2:0] valid_bytes
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [1:0]  m_tuser,   // [1:0] word_index
    output logic        m_tlast    // last_word
);
    import md5_pkg::*;

    md5_cmd_t    cmd;
    md5_status_t status;

    // Sequencer
    md5_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Buffer, round unit and digest output
    md5_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== test/tb_md5_digest_engine_core.sv =====
// Self-checking testbench for the streaming MD5 digest engine core.
`timescale 1ns / 1ps

module tb_md5_digest_engine_core;

    typedef md5_pkg::word_t word_t;

    // One message word request as it goes onto the input stream
    typedef struct {
        word_t      word;
        logic [2:0] nbytes;
        logic       eom;
        logic       hold;   // sender waits for all digests before this one
    } msg_req_t;

    // One digest word as it leaves the block
    typedef struct {
        word_t      word;
        logic [1:0] idx;
        logic       last;
    } digest_t;

    localparam int    STALL_LIMIT = 5000;
    localparam int    DRAIN_WAIT  = 200;
    localparam int    IDLE_PCT    = 17;
    localparam int    RAND_ITEMS  = 280;
    localparam word_t PAD_WORD    = 32'h0000_0080;

    localparam word_t CHAIN_SEED [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };
    localparam word_t STEP_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int unsigned IDX_MUL [4]    = '{1, 5, 3, 7};
    localparam int unsigned IDX_OFF [4]    = '{0, 1, 5, 0};
    localparam int unsigned ROT_TAB [4][4] = '{'{7, 12, 17, 22}, '{5, 9, 14, 20},
                                               '{4, 11, 16, 23}, '{6, 10, 15, 21}};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    md5_digest_engine_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock: 12 ns period
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    msg_req_t pending_reqs [$];
    digest_t  digest_q [$];

    // Hash state mirrored from accepted requests
    word_t       chain [4];
    word_t       blk [16];
    int unsigned fill;
    logic [63:0] byte_cnt;

    int  err_cnt;
    int  taken_cnt;
    int  msg_cnt;
    int  digest_cnt;
    int  stall_cnt;
    bit  in_taken;
    bit  calm;

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
        err_cnt++;
    endtask

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // 64-step compression of the buffered block into the chain
    task automatic md5_compress();
        word_t       a, b, c, d, f, sum, nb;
        int unsigned r, q, g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int k = 0; k < 64; k++) begin
            r = k / 16;
            q = k % 16;
            g = (IDX_MUL[r] * q + IDX_OFF[r]) % 16;
            case (r)
                0:       f = (b & c) | (~b & d);
                1:       f = (d & b) | (~d & c);
                2:       f = b ^ c ^ d;
                default: f = c ^ (b | ~d);
            endcase
            sum = a + f + STEP_K[k] + blk[g];
            nb  = b + rotl(sum, ROT_TAB[r][q % 4]);
            a   = d;
            d   = c;
            c   = b;
            b   = nb;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endtask

    task automatic md5_absorb(input word_t w);
        blk[fill] = w;
        fill = (fill + 1) % 16;
        if (fill == 0)
            md5_compress();
    endtask

    // Fold one accepted request into the hash; queue the digest on message end
    task automatic md5_hash_request(input word_t w, input logic [2:0] nb_in, input logic eom);
        int unsigned nb;
        word_t       keep;
        logic [63:0] bits;
        digest_t     dg;
        nb = (nb_in > 3'd4) ? 4 : nb_in;
        if (!eom) begin
            byte_cnt += 4;
            md5_absorb(w);
            return;
        end
        byte_cnt += nb;
        if (nb < 4) begin
            keep = (nb == 0) ? 32'h0 : (32'hffff_ffff >> (32 - 8 * nb));
            md5_absorb((w & keep) | (PAD_WORD << (8 * nb)));
        end else begin
            md5_absorb(w);
            md5_absorb(PAD_WORD);
        end
        while (fill != 14)
            md5_absorb(32'h0);
        bits = byte_cnt << 3;
        md5_absorb(bits[31:0]);
        md5_absorb(bits[63:32]);
        for (int i = 0; i < 4; i++) begin
            dg.word = chain[i];
            dg.idx  = i[1:0];
            dg.last = (i == 3);
            digest_q.push_back(dg);
        end
        chain    = CHAIN_SEED;
        fill     = 0;
        byte_cnt = '0;
        msg_cnt++;
    endtask

    task automatic queue_req(input word_t w, input logic [2:0] nb, input logic eom,
                             input logic hold);
        msg_req_t r;
        r.word   = w;
        r.nbytes = nb;
        r.eom    = eom;
        r.hold   = hold;
        pending_reqs.push_back(r);
    endtask

    // One whole message: nwords full words then a closing word
    task automatic queue_message(input int nwords, input logic hold);
        word_t w;
        for (int i = 0; i <= nwords; i++) begin
            case ($urandom_range(9))
                0:       w = 32'h0;
                1:       w = 32'hffff_ffff;
                default: w = $urandom;
            endcase
            queue_req(w, 3'($urandom_range(7)), (i == nwords), hold && (i == 0));
        end
    endtask

    // Input driver: new request at the falling edge once the last one is taken
    always @(negedge aclk) begin
        msg_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_reqs.size() != 0
                && !(pending_reqs[0].hold && digest_q.size() != 0)
                && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.word;
                s_tuser  <= nxt.nbytes;
                s_tlast  <= nxt.eom;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: predict on accepted requests, check accepted digest words
    always @(posedge aclk) begin
        digest_t want;
        in_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                taken_cnt++;
                md5_hash_request(s_tdata, s_tuser, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                digest_cnt++;
                if (digest_q.size() == 0) begin
                    report_mismatch("unexpected digest word", m_tdata, 32'h0);
                end else begin
                    want = digest_q.pop_front();
                    if (m_tdata !== want.word)
                        report_mismatch($sformatf("digest_word[%0d]", want.idx),
                                        m_tdata, want.word);
                    if (m_tuser !== want.idx)
                        report_mismatch("word_index", 32'(m_tuser), 32'(want.idx));
                    if (m_tlast !== want.last)
                        report_mismatch("last_word", 32'(m_tlast), 32'(want.last));
                end
            end
            calm = (taken_cnt >= 110 && taken_cnt < 190);
            // Watchdog on cycles with no traffic on either side
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("Timeout after %0d idle cycles", stall_cnt);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        chain    = CHAIN_SEED;
        fill     = 0;
        byte_cnt = '0;
        err_cnt  = 0;
        taken_cnt  = 0;
        msg_cnt    = 0;
        digest_cnt = 0;
        stall_cnt  = 0;
        in_taken   = 1'b0;
        calm       = 1'b0;

        // Directed: single-word messages over every valid byte count
        queue_req(32'hffff_ffff, 3'd0, 1'b1, 1'b0);   // empty message, junk bits dropped
        queue_req(32'hffff_ffff, 3'd1, 1'b1, 1'b0);
        queue_req(32'h0000_0000, 3'd2, 1'b1, 1'b0);
        queue_req(32'h0063_6261, 3'd3, 1'b1, 1'b0);   // "abc"
        queue_req(32'hffff_ffff, 3'd4, 1'b1, 1'b0);   // full word, marker in next word
        queue_req(32'h1234_5678, 3'd7, 1'b1, 1'b0);   // oversized count acts as four
        // Directed: 12 words + full closing word, length just fits this block
        for (int i = 0; i < 12; i++)
            queue_req((i % 2) ? 32'hffff_ffff : 32'h0, i[2:0], 1'b0, 1'b0);
        queue_req(32'hffff_ffff, 3'd4, 1'b1, 1'b0);
        // Directed: one ignored-count word then a short close
        queue_req(32'ha5a5_5a5a, 3'd5, 1'b0, 1'b0);
        queue_req(32'hdead_beef, 3'd3, 1'b1, 1'b0);

        // Random messages; the first one waits for the directed digests to drain
        queue_message(3, 1'b1);
        while (pending_reqs.size() < RAND_ITEMS) begin
            case ($urandom_range(9))
                0, 1:    queue_message($urandom_range(12, 17), 1'b0);  // padding boundary
                2:       queue_message($urandom_range(30, 64), 1'b0);  // multi-block
                3:       queue_message($urandom_range(2, 8), 1'b1);    // drain first
                default: queue_message($urandom_range(0, 20), 1'b0);
            endcase
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (digest_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d message words in %0d messages, %0d digest words checked",
                 taken_cnt, msg_cnt, digest_cnt);
        $display("Byte counts 0..7 on closing words, padding spill, back-pressure on both sides");
        if (err_cnt == 0 && digest_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d digest words never seen", err_cnt, digest_q.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
